[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the RTL folder.
// Depends on nothing; the clock and reset are named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SVP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svp assertion failed");

// Next-cycle implication, off while reset is high.
`define SVP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svp assertion failed");

`endif

[hw/rtl/svp_pkg.sv]
// Package of the semantic version parser: phase codes, character codes,
// the result type and character class functions. Depends on nothing.
package svp_pkg;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_CORE  = 4'b0010,
      PH_PRE   = 4'b0100,
      PH_BUILD = 4'b1000
   } phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LOW_V = 8'h76;
   localparam logic [7:0] CH_UP_V  = 8'h56;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Small saturating counts of digits and identifier characters
   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_MANY = 2'd2;

   localparam logic [1:0] LAST_CORE = 2'd2;

   typedef struct packed {
      logic        is_valid;
      logic [31:0] major_number;
      logic [31:0] minor_number;
      logic [31:0] patch_number;
      logic        has_prerelease;
      logic        has_build;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DASH);
   endfunction

endpackage

[hw/rtl/semantic_version_parser_core.sv]
// Semantic version parser: top level with the input and result registers.
// Depends on svp_pkg and svp_scan.
//
// Usage:
//  - req channel: one ASCII byte of version text per item on req_text_byte;
//    a zero byte ends the string. An item is taken at a clock edge with
//    req_valid high and req_stall low.
//  - rsp channel: one item per string, produced by its zero byte, with the
//    validity flag, the three core numbers and the prerelease/build flags.
//  - rsp_valid rises once the zero byte has passed the input register and
//    then the result register; the receiver can take the result at
//    the following edge.
//  - Throughput: one byte per cycle while the receiver does not stall; the
//    parse state updates in one pass of logic from input to result register.
//  - When the receiver stalls, the result holds in its register, the byte
//    behind it waits in the input register, and req_stall rises only once
//    both are occupied.
//  - Synchronous reset empties both registers and returns the parser to
//    the start of a string.
module semantic_version_parser_core import svp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_valid,
   output logic [31:0] rsp_major_number,
   output logic [31:0] rsp_minor_number,
   output logic [31:0] rsp_patch_number,
   output logic        rsp_has_prerelease,
   output logic        rsp_has_build
);

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   logic       out_free;
   logic       step;
   logic       req_take;
   logic       scan_vld;
   result_type scan_res;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   svp_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .text_byte    (in_byte_ff),
      .result_valid (scan_vld),
      .result       (scan_res)
   );

   // Hold the incoming item until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (step) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
      end
   end

   // Load a result, or drop it once the receiver takes it
   always_comb begin
      out_vld_in = out_vld_ff;
      if (step && scan_vld) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && scan_vld) begin
         out_ff <= scan_res;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_is_valid       = out_ff.is_valid;
   assign rsp_major_number   = out_ff.major_number;
   assign rsp_minor_number   = out_ff.minor_number;
   assign rsp_patch_number   = out_ff.patch_number;
   assign rsp_has_prerelease = out_ff.has_prerelease;
   assign rsp_has_build      = out_ff.has_build;

endmodule

[hw/rtl/svp_scan.sv]
// Parse state of the semantic version parser and its one-byte update.
// Depends on svp_pkg; driven by the top level's input register.
module svp_scan import svp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] text_byte,
   output logic       result_valid,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  core_idx_ff, core_idx_in;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  dig_cnt_ff, dig_cnt_in;
   logic        first_zero_ff, first_zero_in;
   logic [1:0]  id_len_ff, id_len_in;
   logic        id_digits_ff, id_digits_in;
   logic        id_lead_zero_ff, id_lead_zero_in;
   logic [31:0] core_ff [3];
   logic [31:0] core_in [3];
   logic        saw_pre_ff, saw_pre_in;
   logic        saw_build_ff, saw_build_in;
   logic        failed_ff, failed_in;

   logic        is_end;
   logic        core_go;
   logic        ident_go;
   logic        strict;
   logic [35:0] accum_next;
   logic        number_ok;
   logic        ident_ok;

   assign is_end   = (text_byte == CH_NUL);
   assign core_go  = ((phase_ff == PH_CORE) && !failed_ff) ||
                     ((phase_ff == PH_START) && !is_end &&
                      (text_byte != CH_LOW_V) && (text_byte != CH_UP_V));
   assign ident_go = ((phase_ff == PH_PRE) || (phase_ff == PH_BUILD)) && !failed_ff;
   assign strict   = (phase_ff == PH_PRE);

   // Accumulate times ten plus the new digit
   assign accum_next = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                       {32'd0, text_byte[3:0]};

   assign number_ok = (dig_cnt_ff != CNT_NONE) &&
                      !((dig_cnt_ff == CNT_MANY) && first_zero_ff);
   assign ident_ok  = (id_len_ff != CNT_NONE) &&
                      !(strict && id_digits_ff && (id_len_ff == CNT_MANY) && id_lead_zero_ff);

   assign result_valid = step && is_end;

   // Next state for one byte, then the result and a restart on the terminator
   always_comb begin
      phase_in        = phase_ff;
      core_idx_in     = core_idx_ff;
      accum_in        = accum_ff;
      dig_cnt_in      = dig_cnt_ff;
      first_zero_in   = first_zero_ff;
      id_len_in       = id_len_ff;
      id_digits_in    = id_digits_ff;
      id_lead_zero_in = id_lead_zero_ff;
      core_in         = core_ff;
      saw_pre_in      = saw_pre_ff;
      saw_build_in    = saw_build_ff;
      failed_in       = failed_ff;

      if (phase_ff == PH_START) begin
         if (is_end) begin
            failed_in = 1'b1;
         end else begin
            phase_in = PH_CORE;
         end
      end

      if (core_go) begin
         if (is_digit(text_byte)) begin
            if (dig_cnt_ff == CNT_NONE) begin
               first_zero_in = (text_byte == CH_ZERO);
            end
            if (dig_cnt_ff != CNT_MANY) begin
               dig_cnt_in = dig_cnt_ff + CNT_ONE;
            end
            accum_in = accum_next[31:0];
            if (accum_next[35:32] != 4'd0) begin
               failed_in = 1'b1;
            end
         end else if (!number_ok) begin
            failed_in = 1'b1;
         end else begin
            core_in[core_idx_ff] = accum_ff;
            if (text_byte == CH_DOT) begin
               if (core_idx_ff == LAST_CORE) begin
                  failed_in = 1'b1;
               end else begin
                  core_idx_in   = core_idx_ff + 2'd1;
                  accum_in      = '0;
                  dig_cnt_in    = CNT_NONE;
                  first_zero_in = 1'b0;
               end
            end else if (text_byte == CH_DASH) begin
               saw_pre_in      = 1'b1;
               phase_in        = PH_PRE;
               id_len_in       = CNT_NONE;
               id_digits_in    = 1'b1;
               id_lead_zero_in = 1'b0;
            end else if (text_byte == CH_PLUS) begin
               saw_build_in    = 1'b1;
               phase_in        = PH_BUILD;
               id_len_in       = CNT_NONE;
               id_digits_in    = 1'b1;
               id_lead_zero_in = 1'b0;
            end else if (!is_end) begin
               failed_in = 1'b1;
            end
         end
      end

      if (ident_go) begin
         if (is_ident_char(text_byte)) begin
            if (id_len_ff == CNT_NONE) begin
               id_lead_zero_in = (text_byte == CH_ZERO);
            end
            if (!is_digit(text_byte)) begin
               id_digits_in = 1'b0;
            end
            if (id_len_ff != CNT_MANY) begin
               id_len_in = id_len_ff + CNT_ONE;
            end
         end else if (!ident_ok) begin
            failed_in = 1'b1;
         end else if (text_byte == CH_DOT) begin
            id_len_in       = CNT_NONE;
            id_digits_in    = 1'b1;
            id_lead_zero_in = 1'b0;
         end else if ((text_byte == CH_PLUS) && strict) begin
            saw_build_in    = 1'b1;
            phase_in        = PH_BUILD;
            id_len_in       = CNT_NONE;
            id_digits_in    = 1'b1;
            id_lead_zero_in = 1'b0;
         end else if (!is_end) begin
            failed_in = 1'b1;
         end
      end

      // Report what the string left behind
      result.is_valid       = !failed_in;
      result.major_number   = failed_in ? '0 : core_in[0];
      result.minor_number   = failed_in ? '0 : core_in[1];
      result.patch_number   = failed_in ? '0 : core_in[2];
      result.has_prerelease = !failed_in && saw_pre_in;
      result.has_build      = !failed_in && saw_build_in;

      // Restart for the next string
      if (is_end) begin
         phase_in        = PH_START;
         core_idx_in     = '0;
         accum_in        = '0;
         dig_cnt_in      = CNT_NONE;
         first_zero_in   = 1'b0;
         id_len_in       = CNT_NONE;
         id_digits_in    = 1'b1;
         id_lead_zero_in = 1'b0;
         core_in[0]      = '0;
         core_in[1]      = '0;
         core_in[2]      = '0;
         saw_pre_in      = 1'b0;
         saw_build_in    = 1'b0;
         failed_in       = 1'b0;
      end
   end

   // Advance the state on each byte that leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         core_idx_ff     <= '0;
         accum_ff        <= '0;
         dig_cnt_ff      <= CNT_NONE;
         first_zero_ff   <= 1'b0;
         id_len_ff       <= CNT_NONE;
         id_digits_ff    <= 1'b1;
         id_lead_zero_ff <= 1'b0;
         core_ff[0]      <= '0;
         core_ff[1]      <= '0;
         core_ff[2]      <= '0;
         saw_pre_ff      <= 1'b0;
         saw_build_ff    <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         core_idx_ff     <= core_idx_in;
         accum_ff        <= accum_in;
         dig_cnt_ff      <= dig_cnt_in;
         first_zero_ff   <= first_zero_in;
         id_len_ff       <= id_len_in;
         id_digits_ff    <= id_digits_in;
         id_lead_zero_ff <= id_lead_zero_in;
         core_ff         <= core_in;
         saw_pre_ff      <= saw_pre_in;
         saw_build_ff    <= saw_build_in;
         failed_ff       <= failed_in;
      end
   end

endmodule

[hw/rtl/svp_checker.sv]
// Port checker for the semantic version parser, bound to its top level.
// Depends on assert_macros.svh and the top level's port names.
`include "assert_macros.svh"

module svp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_is_valid,
   input logic [31:0] rsp_major_number,
   input logic [31:0] rsp_minor_number,
   input logic [31:0] rsp_patch_number,
   input logic        rsp_has_prerelease,
   input logic        rsp_has_build
);

   // Keep a stalled result in place
   `SVP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `SVP_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_is_valid) && $stable(rsp_major_number) && $stable(rsp_minor_number) && $stable(rsp_patch_number) && $stable(rsp_has_prerelease) && $stable(rsp_has_build))

   // Clear every field of a rejected string
   `SVP_ASSERT_IMPL(a_invalid_zero, rsp_valid && !rsp_is_valid, (rsp_major_number == 32'd0) && (rsp_minor_number == 32'd0) && (rsp_patch_number == 32'd0) && !rsp_has_prerelease && !rsp_has_build)

   // A fresh result follows a taken terminator, through the input and result registers
   `SVP_ASSERT_IMPL(a_rsp_latency, $rose(rsp_valid), $past(req_valid && !req_stall && (req_text_byte == 8'd0), 2))

endmodule

bind semantic_version_parser_core svp_checker u_svp_checker (.*);
